// ----- design/cgen_pkg.sv -----
package cgen_pkg;

   // Coordinate widths
   localparam int READ_COORD_BITS   = 16;
   localparam int GENOME_COORD_BITS = 40;
   localparam int READ_POS_BITS     = READ_COORD_BITS + 1;   // combined two-mate read coordinate
   localparam int READ_END_BITS     = READ_POS_BITS + 1;     // read start + length
   localparam int GENOME_END_BITS   = GENOME_COORD_BITS + 1; // genome start + length
   localparam int CLIP_BITS         = 16;
   localparam int OP_LEN_BITS       = 40;

   // Up to four operations per exon: S/I, N/D, M, S
   localparam int OPS_MAX     = 4;
   localparam int OP_CNT_BITS = $clog2(OPS_MAX + 1);
   localparam int OP_IDX_BITS = $clog2(OPS_MAX);

   typedef enum logic [2:0] {
      OP_M = 3'd0,
      OP_I = 3'd1,
      OP_D = 3'd2,
      OP_N = 3'd3,
      OP_S = 3'd4
   } op_code_type;

   typedef enum logic [1:0] {
      CSR_CLIP5P_MATE0 = 2'd0,
      CSR_CLIP5P_MATE1 = 2'd1,
      CSR_CLIP3P_MATE0 = 2'd2,
      CSR_CLIP3P_MATE1 = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [READ_POS_BITS-1:0]     exon_read_start;
      logic [GENOME_COORD_BITS-1:0] exon_genome_start;
      logic [READ_COORD_BITS-1:0]   exon_length;
      logic                         mate_index;
      logic                         strand;
      logic                         junction_before;
      logic                         first_of_mate;
      logic                         last_of_mate;
      logic [READ_COORD_BITS-1:0]   left_read_length;
      logic [READ_COORD_BITS-1:0]   left_original_length;
      logic [READ_COORD_BITS-1:0]   mate_original_length;
   } req_type;

   typedef struct packed {
      logic [OP_LEN_BITS-1:0] op_length;
      op_code_type            op_code;
      logic                   mate_done;
   } rsp_type;

   typedef struct packed {
      logic [CLIP_BITS-1:0] clip5p_mate0;
      logic [CLIP_BITS-1:0] clip5p_mate1;
      logic [CLIP_BITS-1:0] clip3p_mate0;
      logic [CLIP_BITS-1:0] clip3p_mate1;
   } clip_type;

   // Packed, in-order operation list of one exon; op[0] goes out first
   typedef struct packed {
      rsp_type [OPS_MAX-1:0]  op;
      logic [OP_CNT_BITS-1:0] count;
   } op_set_type;

endpackage

// ----- design/cgen_csr.sv -----
module cgen_csr (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  cgen_pkg::csr_index_type   csr_index,
   input  logic [cgen_pkg::CLIP_BITS-1:0] csr_wdata,
   output cgen_pkg::clip_type        clip
);
   import cgen_pkg::*;

   clip_type clip_ff;
   clip_type clip_in;

   assign csr_ready = 1'b1;
   assign clip      = clip_ff;

   always_comb begin
      clip_in = clip_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_CLIP5P_MATE0: clip_in.clip5p_mate0 = csr_wdata;
            CSR_CLIP5P_MATE1: clip_in.clip5p_mate1 = csr_wdata;
            CSR_CLIP3P_MATE0: clip_in.clip3p_mate0 = csr_wdata;
            CSR_CLIP3P_MATE1: clip_in.clip3p_mate1 = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_ff <= '0;
      end else begin
         clip_ff <= clip_in;
      end
   end

endmodule

// ----- design/cgen_ops.sv -----
module cgen_ops (
   input  logic                 clock,
   input  logic                 reset,
   input  cgen_pkg::req_type    item,
   input  logic                 load,
   input  cgen_pkg::clip_type   clip,
   output cgen_pkg::op_set_type op_set
);
   import cgen_pkg::*;

   // Per-mate state, advanced when an exon's ops move to the emitter
   logic [READ_END_BITS-1:0]   prev_read_end_ff,   prev_read_end_in;
   logic [GENOME_END_BITS-1:0] prev_genome_end_ff, prev_genome_end_in;
   logic [CLIP_BITS-1:0]       left_trim_ff,       left_trim_in;
   logic                       left_seg_ff,        left_seg_in;

   logic [CLIP_BITS-1:0]       trim_sel;
   logic                       seg_new;
   logic [CLIP_BITS-1:0]       trim_use;
   logic                       seg_use;
   logic [READ_END_BITS-1:0]   lead_sum;
   logic [READ_END_BITS-1:0]   lead_base;
   logic [READ_END_BITS-1:0]   lead_clip;
   logic [READ_END_BITS-1:0]   read_start_x;
   logic [READ_END_BITS-1:0]   gap_read;
   logic [GENOME_END_BITS-1:0] genome_start_x;
   logic [GENOME_END_BITS-1:0] gap_genome;
   logic [READ_END_BITS:0]     end_ref;
   logic [READ_END_BITS:0]     consumed;
   logic [READ_END_BITS:0]     trail_clip;

   always_comb begin
      // Left trim: forward strand takes mate0 5' / mate1 3', reverse the opposite
      if (item.strand) begin
         trim_sel = item.mate_index ? clip.clip5p_mate1 : clip.clip3p_mate0;
      end else begin
         trim_sel = item.mate_index ? clip.clip3p_mate1 : clip.clip5p_mate0;
      end
      seg_new  = item.exon_read_start < READ_POS_BITS'(item.left_read_length);
      trim_use = item.first_of_mate ? trim_sel : left_trim_ff;
      seg_use  = item.first_of_mate ? seg_new  : left_seg_ff;

      // Leading soft clip, clamped at zero
      lead_sum  = READ_END_BITS'(trim_sel) + READ_END_BITS'(item.exon_read_start);
      lead_base = seg_new ? '0 : READ_END_BITS'(item.left_read_length) + READ_END_BITS'(1);
      lead_clip = (lead_sum > lead_base) ? lead_sum - lead_base : '0;

      // Gaps to the previous exon, clamped at zero
      read_start_x   = READ_END_BITS'(item.exon_read_start);
      gap_read       = (read_start_x > prev_read_end_ff) ? read_start_x - prev_read_end_ff : '0;
      genome_start_x = GENOME_END_BITS'(item.exon_genome_start);
      gap_genome     = (genome_start_x > prev_genome_end_ff) ?
                       genome_start_x - prev_genome_end_ff : '0;

      // Trailing soft clip, clamped at zero
      end_ref    = seg_use ? (READ_END_BITS + 1)'(item.left_original_length) :
                   (READ_END_BITS + 1)'(item.left_read_length) + (READ_END_BITS + 1)'(1) +
                   (READ_END_BITS + 1)'(item.mate_original_length);
      consumed   = (READ_END_BITS + 1)'(item.exon_read_start) +
                   (READ_END_BITS + 1)'(item.exon_length) + (READ_END_BITS + 1)'(trim_use);
      trail_clip = (end_ref > consumed) ? end_ref - consumed : '0;
   end

   // Candidate ops in output order, then packed to the front
   rsp_type                 cand [OPS_MAX];
   logic [OPS_MAX-1:0]      emit;
   logic [OP_CNT_BITS-1:0]  pos;
   logic [OP_CNT_BITS-1:0]  last_pos;

   always_comb begin
      if (item.first_of_mate) begin
         cand[0] = '{op_length: OP_LEN_BITS'(lead_clip), op_code: OP_S, mate_done: 1'b0};
         emit[0] = lead_clip != '0;
      end else begin
         cand[0] = '{op_length: OP_LEN_BITS'(gap_read), op_code: OP_I, mate_done: 1'b0};
         emit[0] = gap_read != '0;
      end
      cand[1] = '{op_length: OP_LEN_BITS'(gap_genome),
                  op_code: (item.junction_before ? OP_N : OP_D), mate_done: 1'b0};
      emit[1] = !item.first_of_mate && (item.junction_before || gap_genome != '0);
      cand[2] = '{op_length: OP_LEN_BITS'(item.exon_length), op_code: OP_M, mate_done: 1'b0};
      emit[2] = 1'b1;
      cand[3] = '{op_length: OP_LEN_BITS'(trail_clip), op_code: OP_S, mate_done: 1'b0};
      emit[3] = item.last_of_mate && trail_clip != '0;

      op_set = '0;
      pos    = '0;
      for (int i = 0; i < OPS_MAX; i++) begin
         if (emit[i]) begin
            op_set.op[pos[OP_IDX_BITS-1:0]] = cand[i];
            pos = pos + OP_CNT_BITS'(1);
         end
      end
      last_pos = pos - OP_CNT_BITS'(1);
      op_set.op[last_pos[OP_IDX_BITS-1:0]].mate_done = item.last_of_mate;
      op_set.count = pos;
   end

   always_comb begin
      prev_read_end_in   = prev_read_end_ff;
      prev_genome_end_in = prev_genome_end_ff;
      left_trim_in       = left_trim_ff;
      left_seg_in        = left_seg_ff;
      if (load) begin
         prev_read_end_in   = read_start_x + READ_END_BITS'(item.exon_length);
         prev_genome_end_in = genome_start_x + GENOME_END_BITS'(item.exon_length);
         if (item.first_of_mate) begin
            left_trim_in = trim_sel;
            left_seg_in  = seg_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_read_end_ff   <= '0;
         prev_genome_end_ff <= '0;
         left_trim_ff       <= '0;
         left_seg_ff        <= 1'b1;
      end else begin
         prev_read_end_ff   <= prev_read_end_in;
         prev_genome_end_ff <= prev_genome_end_in;
         left_trim_ff       <= left_trim_in;
         left_seg_ff        <= left_seg_in;
      end
   end

endmodule

// ----- design/cgen_emit.sv -----
module cgen_emit (
   input  logic                 clock,
   input  logic                 reset,
   input  cgen_pkg::op_set_type op_set,
   input  logic                 load,
   output logic                 load_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output cgen_pkg::rsp_type    rsp_data
);
   import cgen_pkg::*;

   // Shift queue of pending ops; slot 0 is the output register
   rsp_type [OPS_MAX-1:0]  ops_ff, ops_in;
   logic [OP_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                   rsp_take;

   assign rsp_valid  = cnt_ff != '0;
   assign rsp_data   = ops_ff[0];
   assign rsp_take   = rsp_valid && rsp_ready;
   assign load_ready = (cnt_ff == '0) || (cnt_ff == OP_CNT_BITS'(1) && rsp_ready);

   always_comb begin
      ops_in = ops_ff;
      cnt_in = cnt_ff;
      if (load) begin
         ops_in = op_set.op;
         cnt_in = op_set.count;
      end else if (rsp_take) begin
         for (int i = 0; i < OPS_MAX - 1; i++) begin
            ops_in[i] = ops_ff[i+1];
         end
         cnt_in = cnt_ff - OP_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      ops_ff <= ops_in;
   end

`ifndef SYNTHESIS
   a_load_count: assert property (@(posedge clock) disable iff (reset)
      load |-> (op_set.count != '0 && op_set.count <= OP_CNT_BITS'(OPS_MAX)))
      else $error("op set count out of range");

   a_load_fills: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid)
      else $error("loaded ops not presented");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (cnt_ff == $past(cnt_ff) && $stable(ops_ff[0])))
      else $error("pending op changed under stall");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= OP_CNT_BITS'(OPS_MAX))
      else $error("queue count overflow");
`endif

endmodule

// ----- design/alignment_cigar_op_generator_core.sv -----
// CIGAR operation generator.
// req_*: one aligned exon per item (read/genome start, length, mate, strand,
//   junction flag, first/last-of-mate marks, read lengths).
// rsp_*: one CIGAR op per item (length, code M/I/D/N/S, mate_done on the last
//   op of a mate). An exon yields 1 to 4 ops: leading S or I, N or D, M,
//   trailing S.
// csr_*: four 16-bit clip registers, to be written by the user only while the
//   block is idle (the block does not enforce this); csr_ready is always high.
// An accepted exon is held in the input register, then loaded into the op
//   queue; the single result channel drains the queue one op a cycle while
//   rsp_ready is high, and the next exon loads as the last op leaves.
// The input register takes the next exon while the current one's ops drain,
//   so req_ready stays high as long as that register is free.
// A stalled receiver holds rsp_data; the queue and then the input register
//   fill, after which req_ready drops.
// Reset (synchronous, active high) clears clip registers, empties the
//   pipeline and returns the mate state to its initial values.
module alignment_cigar_op_generator_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  cgen_pkg::req_type         req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output cgen_pkg::rsp_type         rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  cgen_pkg::csr_index_type   csr_index,
   input  logic [cgen_pkg::CLIP_BITS-1:0] csr_wdata
);
   import cgen_pkg::*;

   clip_type   clip;
   op_set_type op_set;

   // Input register
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    req_take;
   logic    load;
   logic    load_ready;

   // Exon moves from the input register into the op queue
   assign load      = in_valid_ff && load_ready;
   assign req_ready = !in_valid_ff || load;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_data_ff <= req_data;
      end
   end

   cgen_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .clip      (clip)
   );

   // Builds the exon's op list and holds per-mate state
   cgen_ops u_ops (
      .clock  (clock),
      .reset  (reset),
      .item   (in_data_ff),
      .load   (load),
      .clip   (clip),
      .op_set (op_set)
   );

   // Serializes ops onto the result channel
   cgen_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .op_set     (op_set),
      .load       (load),
      .load_ready (load_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTHESIS
   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      req_take |=> in_valid_ff)
      else $error("accepted item not registered");

   a_wait_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !load) |=> (in_valid_ff && $stable(in_data_ff)))
      else $error("waiting item lost or changed");

   a_busy_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && rsp_valid))
      else $error("input blocked with nothing pending");
`endif

endmodule

// ----- tb/sv/tb_alignment_cigar_op_generator_core.sv -----
module tb_alignment_cigar_op_generator_core;
   import cgen_pkg::*;

   // Run limit, set far above the length of the slowest legal run.
   localparam int CYCLE_LIMIT = 200000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   csr_index_type        csr_index = CSR_CLIP5P_MATE0;
   logic [CLIP_BITS-1:0] csr_wdata = '0;

   alignment_cigar_op_generator_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow of the clip registers and of the per-mate state
   logic [CLIP_BITS-1:0]       clip_shadow [4];
   logic [READ_END_BITS-1:0]   last_read_end;
   logic [GENOME_END_BITS-1:0] last_genome_end;
   logic [CLIP_BITS-1:0]       left_trim;
   logic                       in_left_seg;

   req_type exon_queue [$];           // exons waiting for the driver
   rsp_type cigar_ops_expected [$];   // predicted ops, oldest first
   rsp_type want;

   int  errors         = 0;
   int  cycle          = 0;
   int  ops_seen       = 0;
   int  exons_queued   = 0;
   int  exons_accepted = 0;
   int  clip_settings  = 0;
   int  req_gap        = 0;
   int  rsp_stall      = 0;
   bit  quiet          = 1'b0;   // no idling on either side when set

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------
   function automatic rsp_type cigar_op(input logic [GENOME_END_BITS-1:0] len,
                                        input op_code_type code);
      rsp_type op;
      op.op_length = len[OP_LEN_BITS-1:0];
      op.op_code   = code;
      op.mate_done = 1'b0;
      return op;
   endfunction

   // Works out the ops of one accepted exon and queues them.
   function automatic void cigar_predict(input req_type e);
      rsp_type                    ops [OPS_MAX];
      int                         n;
      logic [READ_END_BITS:0]     lead, base, ref_end, used;
      logic [READ_END_BITS-1:0]   read_gap;
      logic [GENOME_END_BITS-1:0] genome_gap;
      n = 0;
      if (e.first_of_mate) begin
         // left trim register depends on strand and mate
         case ({e.strand, e.mate_index})
            2'b00:   left_trim = clip_shadow[CSR_CLIP5P_MATE0];
            2'b01:   left_trim = clip_shadow[CSR_CLIP3P_MATE1];
            2'b10:   left_trim = clip_shadow[CSR_CLIP3P_MATE0];
            default: left_trim = clip_shadow[CSR_CLIP5P_MATE1];
         endcase
         in_left_seg = (e.exon_read_start < READ_POS_BITS'(e.left_read_length));
         base = in_left_seg ? '0 :
                (READ_END_BITS + 1)'(e.left_read_length) + (READ_END_BITS + 1)'(1);
         lead = (READ_END_BITS + 1)'(left_trim) + (READ_END_BITS + 1)'(e.exon_read_start);
         if (lead > base) begin
            ops[n] = cigar_op(GENOME_END_BITS'(lead - base), OP_S);
            n++;
         end
      end else begin
         // gaps against the previous exon, clamped at zero
         read_gap   = (READ_END_BITS'(e.exon_read_start) > last_read_end) ?
                      READ_END_BITS'(e.exon_read_start) - last_read_end : '0;
         genome_gap = (GENOME_END_BITS'(e.exon_genome_start) > last_genome_end) ?
                      GENOME_END_BITS'(e.exon_genome_start) - last_genome_end : '0;
         if (read_gap != '0) begin
            ops[n] = cigar_op(GENOME_END_BITS'(read_gap), OP_I);
            n++;
         end
         if (e.junction_before) begin
            ops[n] = cigar_op(genome_gap, OP_N);   // N even at zero length
            n++;
         end else if (genome_gap != '0) begin
            ops[n] = cigar_op(genome_gap, OP_D);
            n++;
         end
      end
      ops[n] = cigar_op(GENOME_END_BITS'(e.exon_length), OP_M);
      n++;
      if (e.last_of_mate) begin
         ref_end = in_left_seg ? (READ_END_BITS + 1)'(e.left_original_length) :
                   (READ_END_BITS + 1)'(e.left_read_length) + (READ_END_BITS + 1)'(1) +
                   (READ_END_BITS + 1)'(e.mate_original_length);
         used    = (READ_END_BITS + 1)'(e.exon_read_start) +
                   (READ_END_BITS + 1)'(e.exon_length) + (READ_END_BITS + 1)'(left_trim);
         if (ref_end > used) begin
            ops[n] = cigar_op(GENOME_END_BITS'(ref_end - used), OP_S);
            n++;
         end
         ops[n-1].mate_done = 1'b1;
      end
      last_read_end   = READ_END_BITS'(e.exon_read_start) + READ_END_BITS'(e.exon_length);
      last_genome_end = GENOME_END_BITS'(e.exon_genome_start) +
                        GENOME_END_BITS'(e.exon_length);
      for (int i = 0; i < n; i++) cigar_ops_expected = {cigar_ops_expected, ops[i]};
   endfunction

   // ---------------------------------------------------------------
   // Clock and run limit
   // ---------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle++;
      if (cycle > CYCLE_LIMIT) begin
         $display("timeout: %0d ops still pending after %0d cycles",
                  cigar_ops_expected.size(), cycle);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Exon driver: presents queued exons, with random gap bursts
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         req_gap    = 0;
      end else if (req_valid && !req_ready) begin
         // hold item until accepted
      end else begin
         if (req_valid && !quiet && $urandom_range(0, 4) == 0)
            req_gap = $urandom_range(1, 9);
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (exon_queue.size() != 0) begin
            req_data  <= exon_queue.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side: random stall bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b1;
         rsp_stall  = 0;
      end else begin
         if (rsp_stall == 0 && !quiet && $urandom_range(0, 6) == 0)
            rsp_stall = $urandom_range(1, 9);
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: checks ops, then predicts newly accepted exons.
   // An exon's first op cannot leave on the edge that takes the exon,
   // so checking before predicting is safe.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) clip_shadow[i] = '0;
         last_read_end   = '0;
         last_genome_end = '0;
         left_trim       = '0;
         in_left_seg     = 1'b1;
      end else begin
         if (rsp_valid && rsp_ready) begin
            ops_seen++;
            if (cigar_ops_expected.size() == 0) begin
               errors++;
               $error("op with no exon pending: op_length %0d op_code %0d",
                      rsp_data.op_length, rsp_data.op_code);
            end else begin
               want = cigar_ops_expected.pop_front();
               if (rsp_data.op_length !== want.op_length) begin
                  errors++;
                  $error("op_length: expected %0d, actual %0d",
                         want.op_length, rsp_data.op_length);
               end
               if (rsp_data.op_code !== want.op_code) begin
                  errors++;
                  $error("op_code: expected %0d, actual %0d",
                         want.op_code, rsp_data.op_code);
               end
               if (rsp_data.mate_done !== want.mate_done) begin
                  errors++;
                  $error("mate_done: expected %0d, actual %0d",
                         want.mate_done, rsp_data.mate_done);
               end
            end
         end
         if (req_valid && req_ready) begin
            exons_accepted++;
            cigar_predict(req_data);
         end
         if (csr_valid && csr_ready) clip_shadow[csr_index] = csr_wdata;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   // flags: {mate, strand, junction_before, first_of_mate, last_of_mate}
   function automatic req_type exon(input logic [READ_POS_BITS-1:0] rs,
                                    input logic [GENOME_COORD_BITS-1:0] gs,
                                    input logic [READ_COORD_BITS-1:0] len,
                                    input logic [4:0] flags,
                                    input logic [READ_COORD_BITS-1:0] lrl, lorig, morig);
      req_type e;
      e.exon_read_start      = rs;
      e.exon_genome_start    = gs;
      e.exon_length          = len;
      {e.mate_index, e.strand, e.junction_before, e.first_of_mate, e.last_of_mate} = flags;
      e.left_read_length     = lrl;
      e.left_original_length = lorig;
      e.mate_original_length = morig;
      return e;
   endfunction

   task automatic post_exon(input req_type e);
      exon_queue = {exon_queue, e};
      exons_queued++;
   endtask

   // Called at a clock edge; leaves csr_valid high for a following write.
   task automatic write_clip(input csr_index_type idx, input logic [CLIP_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic write_clips(input logic [CLIP_BITS-1:0] c5m0, c5m1, c3m0, c3m1);
      write_clip(CSR_CLIP5P_MATE0, c5m0);
      write_clip(CSR_CLIP5P_MATE1, c5m1);
      write_clip(CSR_CLIP3P_MATE0, c3m0);
      write_clip(CSR_CLIP3P_MATE1, c3m1);
      csr_valid <= 1'b0;
      clip_settings++;
   endtask

   // Blocks until every queued exon is taken and all its ops are checked.
   task automatic drain();
      while (exons_accepted != exons_queued || cigar_ops_expected.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One well-formed mate: 1 to 4 exons in read order with random gaps.
   task automatic queue_mate();
      int                           n_exons;
      logic                         mate, strand, junc;
      logic [READ_COORD_BITS-1:0]   lrl, lorig, morig, len;
      logic [READ_POS_BITS-1:0]     rs;
      logic [GENOME_COORD_BITS-1:0] gs;
      logic [63:0]                  raw;
      n_exons = $urandom_range(1, 4);
      mate    = 1'($urandom_range(0, 1));
      strand  = 1'($urandom_range(0, 1));
      lrl     = READ_COORD_BITS'($urandom_range(20, 300));
      lorig   = lrl + READ_COORD_BITS'($urandom_range(0, 40));
      morig   = READ_COORD_BITS'($urandom_range(20, 340));
      if ($urandom_range(0, 7) == 0)
         rs = READ_POS_BITS'($urandom_range(0, int'(lrl) + 30));   // segment edge cases
      else if (mate)
         rs = READ_POS_BITS'(lrl) + READ_POS_BITS'(1) + READ_POS_BITS'($urandom_range(0, 20));
      else
         rs = READ_POS_BITS'($urandom_range(0, 20));
      raw = {$urandom, $urandom};
      gs  = raw[GENOME_COORD_BITS-1:0];
      for (int k = 0; k < n_exons; k++) begin
         len  = ($urandom_range(0, 15) == 0) ? '0 : READ_COORD_BITS'($urandom_range(1, 80));
         junc = 1'($urandom_range(0, 1));
         post_exon(exon(rs, gs, len, {mate, strand, junc, k == 0, k == n_exons - 1},
                        lrl, lorig, morig));
         // next exon: mostly forward gaps, sometimes none, sometimes overlap
         case ($urandom_range(0, 5))
            0:       rs = rs + READ_POS_BITS'(len);
            1:       rs = rs + READ_POS_BITS'(len) - READ_POS_BITS'($urandom_range(1, 4));
            default: rs = rs + READ_POS_BITS'(len) + READ_POS_BITS'($urandom_range(1, 8));
         endcase
         case ($urandom_range(0, 5))
            0:       gs = gs + GENOME_COORD_BITS'(len);
            1:       gs = gs + GENOME_COORD_BITS'(len) -
                          GENOME_COORD_BITS'($urandom_range(1, 6));
            default: gs = gs + GENOME_COORD_BITS'(len) +
                          GENOME_COORD_BITS'($urandom_range(1, 20000));
         endcase
      end
   endtask

   // Fully random exon: covers every bit of every field.
   task automatic queue_noise();
      logic [127:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom};
      post_exon(raw[$bits(req_type)-1:0]);
   endtask

   // ---------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------
   initial begin
      int target;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Reverse/mate0 trim zero, forward/mate1 trim at max.
      write_clips(16'd7, 16'd11, 16'd0, 16'hFFFF);
      // non-first exon right after reset: gaps against zero state
      post_exon(exon(17'd30, 40'd1000, 16'd10, 5'b00000, 16'd100, 16'd120, 16'd130));
      // junction with zero genome gap still emits N
      post_exon(exon(17'd40, 40'd1010, 16'd10, 5'b00100, 16'd100, 16'd120, 16'd130));
      // single-exon mate, forward mate0: S M S, junction flag ignored
      post_exon(exon(17'd5, 40'd2000, 16'd50, 5'b00111, 16'd100, 16'd120, 16'd0));
      // three-exon mate, reverse mate0: I+N, then D, trailing clip
      post_exon(exon(17'd0, 40'd5000, 16'd20, 5'b01010, 16'd100, 16'd100, 16'd0));
      post_exon(exon(17'd25, 40'd5500, 16'd30, 5'b01100, 16'd100, 16'd100, 16'd0));
      post_exon(exon(17'd55, 40'd5600, 16'd10, 5'b01001, 16'd100, 16'd100, 16'd0));
      // reverse mate0 starting at left_read_length: leading clip negative
      post_exon(exon(17'd60, 40'd7000, 16'd5, 5'b01011, 16'd60, 16'd80, 16'd90));
      // forward mate1 with maximum trim: trailing clip negative
      post_exon(exon(17'd105, 40'd8000, 16'd40, 5'b10011, 16'd100, 16'd120, 16'd80));
      // reverse mate1, start equal to left length, then overlapping exon
      post_exon(exon(17'd100, 40'd9000, 16'd30, 5'b11010, 16'd100, 16'd120, 16'd80));
      post_exon(exon(17'd90, 40'd8990, 16'd40, 5'b11001, 16'd100, 16'd120, 16'd80));
      // non-first exon after a mate closed
      post_exon(exon(17'd300, 40'd9100, 16'd5, 5'b11000, 16'd100, 16'd120, 16'd80));
      // field extremes
      post_exon(exon('1, '1, '1, 5'b11111, '1, '1, '1));
      post_exon(exon('0, '0, '0, 5'b00000, '0, '0, '0));
      post_exon(exon('1, '1, '1, 5'b11101, '1, '1, '1));
      post_exon(exon(17'd0, '1, '0, 5'b00011, '0, '0, '0));
      post_exon(exon('1, '0, '1, 5'b10000, '0, '1, '0));
      post_exon(exon(17'd10, 40'd50, 16'hFFFF, 5'b00011, 16'd20, '1, '1));
      drain();

      // Random part over several clip settings; idle-free in the last one.
      for (int p = 0; p < 4; p++) begin
         case (p)
            0:       write_clips(CLIP_BITS'($urandom_range(0, 30)),
                                 CLIP_BITS'($urandom_range(0, 30)),
                                 CLIP_BITS'($urandom_range(0, 30)),
                                 CLIP_BITS'($urandom_range(0, 30)));
            1:       write_clips('1, '1, '1, '1);
            2:       write_clips('0, '0, '0, '0);
            default: write_clips(CLIP_BITS'($urandom_range(0, 65535)),
                                 CLIP_BITS'($urandom_range(0, 65535)),
                                 CLIP_BITS'($urandom_range(0, 65535)),
                                 CLIP_BITS'($urandom_range(0, 65535)));
         endcase
         if (p == 3) quiet = 1'b1;
         target = exons_queued + 23;
         while (exons_queued < target) begin
            if ($urandom_range(0, 4) == 0) queue_noise();
            else queue_mate();
         end
         drain();
      end

      $display("covered %0d exons giving %0d CIGAR ops, under %0d clip register settings",
               exons_accepted, ops_seen, clip_settings);
      if (errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/cgen_pkg.sv
design/cgen_csr.sv
design/cgen_ops.sv
design/cgen_emit.sv
design/alignment_cigar_op_generator_core.sv
tb/sv/tb_alignment_cigar_op_generator_core.sv
